// ===== src/hbp_pkg.sv =====
`timescale 1ns / 1ps

package hbp_pkg;

  // Table sizes, in index bits
  localparam int GSHARE_MAX_BITS  = 14;
  localparam int BIMODAL_MAX_BITS = 14;
  localparam int CHOOSER_MAX_BITS = 12;

  // Smith counter limits
  localparam int SMITH_MAX_BITS = 8;
  localparam int SMITH_W        = SMITH_MAX_BITS;

  // Configuration port sizes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  // Widest index or counter width handled by the mask logic
  localparam int MAX_AB = (GSHARE_MAX_BITS > BIMODAL_MAX_BITS) ?
                          GSHARE_MAX_BITS : BIMODAL_MAX_BITS;
  localparam int CLR_W  = (MAX_AB > CHOOSER_MAX_BITS) ? MAX_AB : CHOOSER_MAX_BITS;
  localparam int IDX_W  = (CLR_W > SMITH_MAX_BITS) ? CLR_W : SMITH_MAX_BITS;
  localparam int WLOG   = $clog2(IDX_W + 1);
  localparam int W_BITS = (WLOG > CFG_DATA_W) ? WLOG : CFG_DATA_W;
  localparam int HIST_W = GSHARE_MAX_BITS;

  // Counter widths and values
  localparam int CNT_W = 3;
  localparam int CH_W  = 2;
  localparam logic [CNT_W-1:0] CNT_MID = 3'd4;
  localparam logic [CNT_W-1:0] CNT_MAX = 3'd7;
  localparam logic [CH_W-1:0]  CH_MAX  = 2'd3;
  localparam logic [CH_W-1:0]  CH_INIT = 2'd1;

  typedef enum logic [1:0] {
    MODE_SMITH   = 2'd0,
    MODE_BIMODAL = 2'd1,
    MODE_GSHARE  = 2'd2,
    MODE_HYBRID  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE          = 3'd0,
    CFG_SMITH_BITS    = 3'd1,
    CFG_GSHARE_BITS   = 3'd2,
    CFG_HISTORY_BITS  = 3'd3,
    CFG_BIMODAL_BITS  = 3'd4,
    CFG_CHOOSER_BITS  = 3'd5
  } cfg_idx_t;

  // Clamp a width field into 1..hi
  function automatic logic [W_BITS-1:0] clamp_w(input logic [CFG_DATA_W-1:0] v,
                                                input logic [W_BITS-1:0] hi);
    logic [W_BITS-1:0] ve;
    ve = W_BITS'(v);
    if (ve == '0) begin
      return W_BITS'(1);
    end else if (ve > hi) begin
      return hi;
    end
    return ve;
  endfunction

  // Mask with the low w bits set
  function automatic logic [IDX_W-1:0] low_mask(input logic [W_BITS-1:0] w);
    logic [IDX_W-1:0] m;
    for (int i = 0; i < IDX_W; i++) begin
      m[i] = (W_BITS'(i) < w);
    end
    return m;
  endfunction

  // Saturating 3-bit counter step
  function automatic logic [CNT_W-1:0] train3(input logic [CNT_W-1:0] c,
                                              input logic t);
    if (t) begin
      return (c < CNT_MAX) ? c + CNT_W'(1) : c;
    end
    return (c > '0) ? c - CNT_W'(1) : c;
  endfunction

endpackage

// ===== src/hybrid_branch_predictor_unit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in        to block   in_valid / in_stall  branch_pc[31:0], taken
// out       from block out_valid / out_stall predicted_taken, mispredicted, used_gshare
// cfg       to block   cfg_valid / cfg_ready cfg_index[2:0], cfg_data[3:0]
//
// One branch per cycle while in_stall is low. Acceptance registers the table
// reads into stage 1; when stage 1 fires, its result loads the result register.
// The read-modify-write of each table completes as stage 1 fires; a back-to-back hit on the
// same entry is forwarded into the read register.
// After reset a clearing pass writes every table entry, one per cycle;
// in_stall stays high meanwhile. cfg is always ready.
// A stalled result holds the pipeline; in_stall rises only during the clearing
// pass or when the result register and table-read stage are full and stalled.

module hybrid_branch_predictor_unit (
  input  logic                              clk,
  input  logic                              rst,
  // branch input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [31:0]                       branch_pc,
  input  logic                              taken,
  // result output
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              predicted_taken,
  output logic                              mispredicted,
  output logic                              used_gshare,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hbp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hbp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int GB   = hbp_pkg::GSHARE_MAX_BITS;
  localparam int BB   = hbp_pkg::BIMODAL_MAX_BITS;
  localparam int KB   = hbp_pkg::CHOOSER_MAX_BITS;
  localparam int CW   = hbp_pkg::CNT_W;
  localparam int HW   = hbp_pkg::CH_W;
  localparam int SW   = hbp_pkg::SMITH_W;
  localparam int WB   = hbp_pkg::W_BITS;
  localparam int XW   = hbp_pkg::IDX_W;
  localparam int HISW = hbp_pkg::HIST_W;
  localparam int CLW  = hbp_pkg::CLR_W;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  hbp_pkg::mode_t          mode;
  logic [hbp_pkg::CFG_DATA_W-1:0] smith_bits;
  logic [hbp_pkg::CFG_DATA_W-1:0] gshare_index_bits;
  logic [hbp_pkg::CFG_DATA_W-1:0] history_bits;
  logic [hbp_pkg::CFG_DATA_W-1:0] bimodal_index_bits;
  logic [hbp_pkg::CFG_DATA_W-1:0] chooser_index_bits;

  logic cfg_we;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // ---------------------------------------------------------------------
  // Predictor state
  // ---------------------------------------------------------------------
  logic [SW-1:0]   smith_count;
  logic [HISW-1:0] global_history;

  logic [CW-1:0] bim_mem [2**BB];
  logic [CW-1:0] gsh_mem [2**GB];
  logic [HW-1:0] cho_mem [2**KB];

  // Clearing pass after reset
  logic           clearing;
  logic [CLW-1:0] clr_idx;

  // ---------------------------------------------------------------------
  // Pipeline control
  // ---------------------------------------------------------------------
  logic s1_valid;
  logic advance;
  logic accept;
  logic s1_fire;

  // Stage 1 advances when it is empty or the result register can take it
  assign advance  = !s1_valid || !out_valid || !out_stall;
  assign in_stall = clearing || !advance;
  assign accept   = in_valid && !in_stall;
  assign s1_fire  = s1_valid && advance;

  // ---------------------------------------------------------------------
  // Accept stage: indices and history update
  // ---------------------------------------------------------------------
  logic [WB-1:0]   g_w, h_w, b_w, k_w;
  logic [XW-1:0]   g_mask, h_mask_x, b_mask, k_mask;
  logic [HISW-1:0] h_mask, h_top;
  logic [29:0]     pc_word;
  logic [BB-1:0]   acc_bi;
  logic [GB-1:0]   acc_gi;
  logic [KB-1:0]   acc_ci;
  logic [HISW-1:0] global_history_next;

  always_comb begin
    g_w = hbp_pkg::clamp_w(gshare_index_bits, WB'(GB));
    h_w = hbp_pkg::clamp_w(history_bits, WB'(GB));
    b_w = hbp_pkg::clamp_w(bimodal_index_bits, WB'(BB));
    k_w = hbp_pkg::clamp_w(chooser_index_bits, WB'(KB));
    // history never reaches past the gshare index
    if (h_w > g_w) begin
      h_w = g_w;
    end
    g_mask   = hbp_pkg::low_mask(g_w);
    h_mask_x = hbp_pkg::low_mask(h_w);
    b_mask   = hbp_pkg::low_mask(b_w);
    k_mask   = hbp_pkg::low_mask(k_w);
    h_mask   = h_mask_x[HISW-1:0];
    h_top    = h_mask ^ (h_mask >> 1);

    pc_word = branch_pc[31:2];
    acc_bi  = pc_word[BB-1:0] & b_mask[BB-1:0];
    acc_gi  = (pc_word[GB-1:0] & g_mask[GB-1:0]) ^ (global_history & h_mask);
    acc_ci  = pc_word[KB-1:0] & k_mask[KB-1:0];

    // shift right, new outcome enters at the top of the live window
    global_history_next = (((global_history & h_mask) >> 1) |
                           (taken ? h_top : '0)) & h_mask;
  end

  // ---------------------------------------------------------------------
  // Stage 1 registers
  // ---------------------------------------------------------------------
  logic [BB-1:0] s1_bi;
  logic [GB-1:0] s1_gi;
  logic [KB-1:0] s1_ci;
  logic          s1_taken;
  logic [CW-1:0] bim_rd;
  logic [CW-1:0] gsh_rd;
  logic [HW-1:0] cho_rd;

  // ---------------------------------------------------------------------
  // Stage 1: predict and train
  // ---------------------------------------------------------------------
  logic          bp, gp, use_g, pred;
  logic          bim_train, gsh_train, cho_train, smith_train;
  logic [CW-1:0] bim_new, gsh_new;
  logic [HW-1:0] cho_new;
  logic [WB-1:0] sm_w;
  logic [XW-1:0] sm_mask_x;
  logic [SW-1:0] sm_mask, sm_mid;
  logic [SW-1:0] smith_count_next;

  always_comb begin
    bp = (bim_rd >= hbp_pkg::CNT_MID);
    gp = (gsh_rd >= hbp_pkg::CNT_MID);

    sm_w      = hbp_pkg::clamp_w(smith_bits, WB'(hbp_pkg::SMITH_MAX_BITS));
    sm_mask_x = hbp_pkg::low_mask(sm_w);
    sm_mask   = sm_mask_x[SW-1:0];
    sm_mid    = sm_mask ^ (sm_mask >> 1);

    use_g       = 1'b0;
    pred        = 1'b0;
    bim_train   = 1'b0;
    gsh_train   = 1'b0;
    cho_train   = 1'b0;
    smith_train = 1'b0;
    case (mode)
      hbp_pkg::MODE_SMITH: begin
        pred        = (smith_count >= sm_mid);
        smith_train = 1'b1;
      end
      hbp_pkg::MODE_BIMODAL: begin
        pred      = bp;
        bim_train = 1'b1;
      end
      hbp_pkg::MODE_GSHARE: begin
        pred      = gp;
        use_g     = 1'b1;
        gsh_train = 1'b1;
      end
      default: begin
        use_g     = (cho_rd > hbp_pkg::CH_INIT);
        pred      = use_g ? gp : bp;
        gsh_train = use_g;
        bim_train = !use_g;
        cho_train = 1'b1;
      end
    endcase

    bim_new = hbp_pkg::train3(bim_rd, s1_taken);
    gsh_new = hbp_pkg::train3(gsh_rd, s1_taken);

    // chooser leans toward the component that alone was right
    cho_new = cho_rd;
    if (gp == s1_taken && bp != s1_taken) begin
      if (cho_rd < hbp_pkg::CH_MAX) begin
        cho_new = cho_rd + HW'(1);
      end
    end else if (gp != s1_taken && bp == s1_taken) begin
      if (cho_rd > '0) begin
        cho_new = cho_rd - HW'(1);
      end
    end

    smith_count_next = smith_count;
    if (s1_taken) begin
      if (smith_count < sm_mask) begin
        smith_count_next = smith_count + SW'(1);
      end
    end else if (smith_count > '0) begin
      smith_count_next = smith_count - SW'(1);
    end
  end

  // ---------------------------------------------------------------------
  // Table write ports: clearing pass or training
  // ---------------------------------------------------------------------
  logic          bim_we, gsh_we, cho_we;
  logic [BB-1:0] bim_waddr;
  logic [GB-1:0] gsh_waddr;
  logic [KB-1:0] cho_waddr;
  logic [CW-1:0] bim_wdata, gsh_wdata;
  logic [HW-1:0] cho_wdata;

  always_comb begin
    bim_we    = clearing || (s1_fire && bim_train);
    gsh_we    = clearing || (s1_fire && gsh_train);
    cho_we    = clearing || (s1_fire && cho_train);
    bim_waddr = clearing ? clr_idx[BB-1:0] : s1_bi;
    gsh_waddr = clearing ? clr_idx[GB-1:0] : s1_gi;
    cho_waddr = clearing ? clr_idx[KB-1:0] : s1_ci;
    bim_wdata = clearing ? hbp_pkg::CNT_MID : bim_new;
    gsh_wdata = clearing ? hbp_pkg::CNT_MID : gsh_new;
    cho_wdata = clearing ? hbp_pkg::CH_INIT : cho_new;
  end

  // Tables: one write and one registered read per cycle. A read that hits
  // the entry written at the same edge takes the new value.
  always_ff @(posedge clk) begin
    if (bim_we) begin
      bim_mem[bim_waddr] <= bim_wdata;
    end
    if (accept) begin
      bim_rd <= (bim_we && bim_waddr == acc_bi) ? bim_wdata : bim_mem[acc_bi];
    end
  end

  always_ff @(posedge clk) begin
    if (gsh_we) begin
      gsh_mem[gsh_waddr] <= gsh_wdata;
    end
    if (accept) begin
      gsh_rd <= (gsh_we && gsh_waddr == acc_gi) ? gsh_wdata : gsh_mem[acc_gi];
    end
  end

  always_ff @(posedge clk) begin
    if (cho_we) begin
      cho_mem[cho_waddr] <= cho_wdata;
    end
    if (accept) begin
      cho_rd <= (cho_we && cho_waddr == acc_ci) ? cho_wdata : cho_mem[acc_ci];
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_bi    <= acc_bi;
      s1_gi    <= acc_gi;
      s1_ci    <= acc_ci;
      s1_taken <= taken;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      predicted_taken <= pred;
      mispredicted    <= (pred != s1_taken);
      used_gshare     <= use_g;
    end
  end

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  logic [WB-1:0] cfg_sm_w;
  logic [XW-1:0] cfg_sm_mask_x;
  logic [SW-1:0] cfg_sm_mask;

  always_comb begin
    cfg_sm_w      = hbp_pkg::clamp_w(cfg_data, WB'(hbp_pkg::SMITH_MAX_BITS));
    cfg_sm_mask_x = hbp_pkg::low_mask(cfg_sm_w);
    cfg_sm_mask   = cfg_sm_mask_x[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode               <= hbp_pkg::MODE_HYBRID;
      smith_bits         <= hbp_pkg::CFG_DATA_W'(3);
      gshare_index_bits  <= hbp_pkg::CFG_DATA_W'(9);
      history_bits       <= hbp_pkg::CFG_DATA_W'(3);
      bimodal_index_bits <= hbp_pkg::CFG_DATA_W'(7);
      chooser_index_bits <= hbp_pkg::CFG_DATA_W'(8);
      smith_count        <= SW'(4);
      global_history     <= '0;
      clearing           <= 1'b1;
      clr_idx            <= '0;
      s1_valid           <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      // sweep every table entry at least once
      if (clearing) begin
        clr_idx <= clr_idx + CLW'(1);
        if (clr_idx == '1) begin
          clearing <= 1'b0;
        end
      end

      // advance the predictor state in transaction order
      if (accept && (mode == hbp_pkg::MODE_GSHARE || mode == hbp_pkg::MODE_HYBRID)) begin
        global_history <= global_history_next;
      end
      if (s1_fire && smith_train) begin
        smith_count <= smith_count_next;
      end

      if (cfg_we) begin
        case (hbp_pkg::cfg_idx_t'(cfg_index))
          hbp_pkg::CFG_MODE:         mode <= hbp_pkg::mode_t'(cfg_data[1:0]);
          hbp_pkg::CFG_SMITH_BITS: begin
            smith_bits  <= cfg_data;
            // reload to the middle of the new range
            smith_count <= cfg_sm_mask ^ (cfg_sm_mask >> 1);
          end
          hbp_pkg::CFG_GSHARE_BITS:  gshare_index_bits  <= cfg_data;
          hbp_pkg::CFG_HISTORY_BITS: history_bits       <= cfg_data;
          hbp_pkg::CFG_BIMODAL_BITS: bimodal_index_bits <= cfg_data;
          hbp_pkg::CFG_CHOOSER_BITS: chooser_index_bits <= cfg_data;
          default: ;
        endcase
      end

      // stage 1 holds while the result register is stalled
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end

      if (s1_fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/hbp_checker.sv =====
`timescale 1ns / 1ps

module hbp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           predicted_taken,
  input logic                           mispredicted,
  input logic                           used_gshare
);

  // Reset starts the clearing pass, so input is held off
  a_reset_stall: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input not stalled after reset");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(predicted_taken) && $stable(mispredicted)
      && $stable(used_gshare))
    else $error("result payload changed while stalled");

  // After a transaction, input stalls only behind a full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !in_stall || out_valid)
    else $error("input stalled with empty result register");

endmodule

bind hybrid_branch_predictor_unit hbp_checker u_hbp_checker (.*);

// ===== tb/sv/branch_outcome_checker.sv =====
`timescale 1ns / 1ps

module branch_outcome_checker
  import hbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [31:0]           branch_pc,
  input  logic                  taken,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  predicted_taken,
  input  logic                  mispredicted,
  input  logic                  used_gshare,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    pending_verdicts,
  output int                    compared
);

  localparam logic [CFG_DATA_W-1:0] RST_SMITH_BITS   = 4'd3;
  localparam logic [CFG_DATA_W-1:0] RST_GSHARE_BITS  = 4'd9;
  localparam logic [CFG_DATA_W-1:0] RST_HISTORY_BITS = 4'd3;
  localparam logic [CFG_DATA_W-1:0] RST_BIMODAL_BITS = 4'd7;
  localparam logic [CFG_DATA_W-1:0] RST_CHOOSER_BITS = 4'd8;

  typedef struct packed {
    logic predicted;
    logic wrong;
    logic from_gshare;
  } verdict_t;

  verdict_t expected_verdicts[$];

  mode_t                 sel_mode;
  logic [CFG_DATA_W-1:0] smith_w_reg, gshare_w_reg, hist_w_reg, bimodal_w_reg, chooser_w_reg;
  logic [SMITH_W-1:0]    smith_ctr;
  logic [CNT_W-1:0]      bim_tab  [0:(1 << BIMODAL_MAX_BITS)-1];
  logic [CNT_W-1:0]      gsh_tab  [0:(1 << GSHARE_MAX_BITS)-1];
  logic [CH_W-1:0]       pick_tab [0:(1 << CHOOSER_MAX_BITS)-1];
  logic [HIST_W-1:0]     ghist;

  function automatic int unsigned fit_width(input logic [CFG_DATA_W-1:0] v,
                                            input int unsigned hi);
    if (v == '0) return 1;
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  function automatic logic [CNT_W-1:0] nudge(input logic [CNT_W-1:0] c, input logic up);
    if (up) return (c == CNT_MAX) ? c : c + CNT_W'(1);
    return (c == '0) ? c : c - CNT_W'(1);
  endfunction

  function automatic logic [SMITH_W-1:0] smith_middle(input logic [CFG_DATA_W-1:0] w);
    return SMITH_W'(1 << (fit_width(w, SMITH_MAX_BITS) - 1));
  endfunction

  task automatic reset_model();
    sel_mode      = MODE_HYBRID;
    smith_w_reg   = RST_SMITH_BITS;
    gshare_w_reg  = RST_GSHARE_BITS;
    hist_w_reg    = RST_HISTORY_BITS;
    bimodal_w_reg = RST_BIMODAL_BITS;
    chooser_w_reg = RST_CHOOSER_BITS;
    smith_ctr     = smith_middle(RST_SMITH_BITS);
    ghist         = '0;
    foreach (bim_tab[i]) bim_tab[i] = CNT_MID;
    foreach (gsh_tab[i]) gsh_tab[i] = CNT_MID;
    foreach (pick_tab[i]) pick_tab[i] = CH_INIT;
  endtask

  task automatic apply_setting(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_MODE:         sel_mode = mode_t'(data[1:0]);
      CFG_SMITH_BITS: begin
        smith_w_reg = data;
        smith_ctr   = smith_middle(data);
      end
      CFG_GSHARE_BITS:  gshare_w_reg  = data;
      CFG_HISTORY_BITS: hist_w_reg    = data;
      CFG_BIMODAL_BITS: bimodal_w_reg = data;
      CFG_CHOOSER_BITS: chooser_w_reg = data;
      default: ;
    endcase
  endtask

  // shift right, new outcome enters at bit h-1, bits at h and above dropped
  task automatic push_history(input int unsigned h, input logic t);
    int unsigned hm, nh;
    hm = (1 << h) - 1;
    nh = (32'(ghist) & hm) >> 1;
    if (t) nh = nh | (1 << (h - 1));
    ghist = HIST_W'(nh & hm);
  endtask

  task automatic predict_branch(input logic [31:0] pc, input logic t, output verdict_t v);
    int unsigned pcw, g, h, bw, cw, sw, smax;
    logic [BIMODAL_MAX_BITS-1:0] bi;
    logic [GSHARE_MAX_BITS-1:0]  gi;
    logic [CHOOSER_MAX_BITS-1:0] ci;
    logic        bim_says, gsh_says, pred, use_g;
    logic [CH_W-1:0] ch;
    pcw  = 32'(pc[31:2]);
    g    = fit_width(gshare_w_reg, GSHARE_MAX_BITS);
    h    = fit_width(hist_w_reg, GSHARE_MAX_BITS);
    bw   = fit_width(bimodal_w_reg, BIMODAL_MAX_BITS);
    cw   = fit_width(chooser_w_reg, CHOOSER_MAX_BITS);
    if (h > g) h = g;
    bi   = BIMODAL_MAX_BITS'(pcw & ((1 << bw) - 1));
    gi   = GSHARE_MAX_BITS'((pcw & ((1 << g) - 1)) ^ (32'(ghist) & ((1 << h) - 1)));
    ci   = CHOOSER_MAX_BITS'(pcw & ((1 << cw) - 1));
    bim_says = bim_tab[bi] >= CNT_MID;
    gsh_says = gsh_tab[gi] >= CNT_MID;
    pred  = 1'b0;
    use_g = 1'b0;
    case (sel_mode)
      MODE_SMITH: begin
        sw   = fit_width(smith_w_reg, SMITH_MAX_BITS);
        smax = (1 << sw) - 1;
        pred = smith_ctr >= smith_middle(smith_w_reg);
        if (t) begin
          if (32'(smith_ctr) < smax) smith_ctr = smith_ctr + SMITH_W'(1);
        end else if (smith_ctr != '0) begin
          smith_ctr = smith_ctr - SMITH_W'(1);
        end
      end
      MODE_BIMODAL: begin
        pred        = bim_says;
        bim_tab[bi] = nudge(bim_tab[bi], t);
      end
      MODE_GSHARE: begin
        pred        = gsh_says;
        use_g       = 1'b1;
        gsh_tab[gi] = nudge(gsh_tab[gi], t);
        push_history(h, t);
      end
      default: begin
        ch    = pick_tab[ci];
        use_g = ch > CH_INIT;
        if (use_g) begin
          pred        = gsh_says;
          gsh_tab[gi] = nudge(gsh_tab[gi], t);
        end else begin
          pred        = bim_says;
          bim_tab[bi] = nudge(bim_tab[bi], t);
        end
        push_history(h, t);
        if (gsh_says == t && bim_says != t) begin
          if (ch != CH_MAX) ch = ch + CH_W'(1);
        end else if (gsh_says != t && bim_says == t) begin
          if (ch != '0) ch = ch - CH_W'(1);
        end
        pick_tab[ci] = ch;
      end
    endcase
    v.predicted   = pred;
    v.wrong       = pred != t;
    v.from_gshare = use_g;
  endtask

  always @(posedge clk) begin : watch
    verdict_t want;
    if (rst) begin
      reset_model();
      expected_verdicts.delete();
      mismatches = 0;
      compared   = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: result with no branch outstanding (%b %b %b)", $time,
                   predicted_taken, mispredicted, used_gshare);
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          compared++;
          if (predicted_taken !== want.predicted) begin
            $display("%0t: predicted_taken expected %b got %b", $time,
                     want.predicted, predicted_taken);
            mismatches++;
          end
          if (mispredicted !== want.wrong) begin
            $display("%0t: mispredicted expected %b got %b", $time,
                     want.wrong, mispredicted);
            mismatches++;
          end
          if (used_gshare !== want.from_gshare) begin
            $display("%0t: used_gshare expected %b got %b", $time,
                     want.from_gshare, used_gshare);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_branch(branch_pc, taken, want);
        expected_verdicts.push_back(want);
      end
      if (cfg_valid && cfg_ready) apply_setting(cfg_index, cfg_data);
    end
    pending_verdicts = expected_verdicts.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import hbp_pkg::*;

  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int POOL            = 8;
  localparam int LONG_HOLD       = 60;
  localparam int SETTLE_CYCLES   = 4;
  localparam int DRAIN_CYCLES    = 10;

  // indexes past the register list; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  // how a branch in the working set behaves over time
  typedef enum int { ALWAYS_T, NEVER_T, TOGGLE, LOOP, COIN } habit_t;

  // which way a phase pushes the outcome (drives the smith counter to its rails)
  typedef enum int { LEAN_NONE, LEAN_TAKEN, LEAN_NOT } lean_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid, in_stall;
  logic [31:0]           branch_pc;
  logic                  taken;
  logic                  out_valid, out_stall;
  logic                  predicted_taken, mispredicted, used_gshare;
  logic                  cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches, pending_verdicts, compared;

  // knobs shared by the stimulus and the result sink
  bit quiet_sender  = 1'b0;
  bit quiet_sink    = 1'b0;
  int hold_requests = 0;
  int hold_served   = 0;
  int branches_sent = 0;

  // working set of branches for the current phase
  logic [31:0] pool_pc    [POOL];
  habit_t      pool_habit [POOL];
  int          pool_step  [POOL];
  int          pool_trip  [POOL];

  always #1 clk = ~clk;

  hybrid_branch_predictor_unit dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .branch_pc       (branch_pc),
    .taken           (taken),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .predicted_taken (predicted_taken),
    .mispredicted    (mispredicted),
    .used_gshare     (used_gshare),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  branch_outcome_checker outcome_chk (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .branch_pc        (branch_pc),
    .taken            (taken),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .predicted_taken  (predicted_taken),
    .mispredicted     (mispredicted),
    .used_gshare      (used_gshare),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .pending_verdicts (pending_verdicts),
    .compared         (compared)
  );

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Offer one branch and hold it until the block takes it.
  task automatic send_branch(input logic [31:0] pc, input logic t);
    @(negedge clk);
    in_valid  <= 1'b1;
    branch_pc <= pc;
    taken     <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    branches_sent++;
  endtask

  // Drop valid while idling; the payload holds its last value.
  task automatic idle_input(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering, wait out every outstanding prediction, then let the
  // pipeline settle so a following register write finds the block idle.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_verdicts != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // A few probes per mode: address extremes, alternating bits, both outcomes.
  task automatic probe_mode(input mode_t m);
    write_reg(CFG_MODE, CFG_DATA_W'(m));
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'hFFFF_FFFF, 1'b0);
    send_branch(32'h5555_5555, 1'b1);
    send_branch(32'hAAAA_AAAA, 1'b1);
    drain_results();
  endtask

  function automatic mode_t phase_mode(input int p);
    case (p)
      0, 7:       return MODE_SMITH;
      1, 9:       return MODE_BIMODAL;
      2, 5:       return MODE_GSHARE;
      default:    return MODE_HYBRID;
    endcase
  endfunction

  // Write every register for phase p. Widths cycle through below-range,
  // minimum, exact maximum, above-range and random settings.
  task automatic configure_phase(input int p);
    logic [CFG_DATA_W-1:0] s, g, h, b, c;
    mode_t m;
    m = phase_mode(p);
    case (p)
      0, 5: begin
        s = '0; g = '0; h = '0; b = '0; c = '0;
      end
      1, 7: begin
        s = '1; g = '1; h = '1; b = '1; c = '1;
      end
      2, 4: begin
        s = CFG_DATA_W'(SMITH_MAX_BITS);
        g = CFG_DATA_W'(GSHARE_MAX_BITS);
        h = CFG_DATA_W'(GSHARE_MAX_BITS);
        b = CFG_DATA_W'(BIMODAL_MAX_BITS);
        c = CFG_DATA_W'(CHOOSER_MAX_BITS);
      end
      3, 9: begin
        s = 4'd1; g = 4'd1; h = 4'd1; b = 4'd1; c = 4'd1;
      end
      default: begin
        // history deliberately longer than the gshare index
        s = CFG_DATA_W'($urandom_range(0, 15));
        g = CFG_DATA_W'($urandom_range(1, 6));
        h = CFG_DATA_W'($urandom_range(7, 15));
        b = CFG_DATA_W'($urandom_range(0, 15));
        c = CFG_DATA_W'($urandom_range(0, 15));
      end
    endcase
    // upper data bits of the mode write are don't-care
    write_reg(CFG_MODE, {2'($urandom_range(0, 3)), m});
    write_reg(CFG_SMITH_BITS, s);
    write_reg(CFG_GSHARE_BITS, g);
    write_reg(CFG_HISTORY_BITS, h);
    write_reg(CFG_BIMODAL_BITS, b);
    write_reg(CFG_CHOOSER_BITS, c);
    write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_LO : CFG_SPARE_HI,
              CFG_DATA_W'($urandom_range(0, 15)));
  endtask

  // Pick a handful of branches that share low index bits so entries alias
  // and the chooser has something to arbitrate.
  task automatic build_pool();
    for (int i = 0; i < POOL; i++) begin
      pool_pc[i]    = ($urandom & 32'hFFFF_F000) | (32'($urandom_range(0, 63)) << 2)
                      | 32'($urandom_range(0, 3));
      pool_habit[i] = habit_t'($urandom_range(0, 4));
      pool_step[i]  = 0;
      pool_trip[i]  = $urandom_range(2, 6);
    end
  endtask

  // Mostly working-set branches with their own patterns, some pure noise.
  task automatic next_branch(input lean_t lean, output logic [31:0] pc, output logic t);
    int i;
    if ($urandom_range(0, 3) == 0) begin
      pc = $urandom;
      t  = 1'($urandom_range(0, 1));
    end else begin
      i  = $urandom_range(0, POOL - 1);
      pc = pool_pc[i];
      case (pool_habit[i])
        ALWAYS_T: t = 1'b1;
        NEVER_T:  t = 1'b0;
        TOGGLE:   t = (pool_step[i] % 2) == 1;
        LOOP:     t = (pool_step[i] % pool_trip[i]) != pool_trip[i] - 1;
        default:  t = 1'($urandom_range(0, 1));
      endcase
      pool_step[i]++;
    end
    if (lean == LEAN_TAKEN) t = $urandom_range(0, 19) != 0;
    else if (lean == LEAN_NOT) t = $urandom_range(0, 19) == 0;
  endtask

  // Result sink: random back-pressure, plus a long counted hold-off on request.
  initial begin : result_sink
    int hold;
    hold      = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served < hold_requests) begin
        hold_served++;
        hold = LONG_HOLD;
      end else if (hold == 0 && !quiet_sink && $urandom_range(0, 3) == 0) begin
        hold = pause_len();
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Hard stop in case the block wedges.
  initial begin : watchdog
    #1_000_000;
    $display("[hybrid_branch_predictor_unit] ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] pc;
    logic        t;
    lean_t       lean;
    int          directed;

    rst       = 1'b1;
    in_valid  = 1'b0;
    branch_pc = '0;
    taken     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MODE;
    cfg_data  = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Hold off until the post-reset table clear is done.
    repeat (3) @(negedge clk);
    while (in_stall) @(negedge clk);

    // Directed: reset settings (hybrid). Same entry back to back exercises
    // forwarding; 0x3 drops its low bits and lands on the same entry as 0.
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'h0000_0003, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b1);
    send_branch(32'hFFFF_FFFF, 1'b0);
    send_branch(32'h5555_5555, 1'b1);
    send_branch(32'hAAAA_AAAA, 1'b0);
    send_branch(32'h0000_0004, 1'b1);
    send_branch(32'h0000_0004, 1'b1);
    send_branch(32'h0000_0004, 1'b1);
    drain_results();
    probe_mode(MODE_SMITH);
    probe_mode(MODE_BIMODAL);
    probe_mode(MODE_GSHARE);
    directed = branches_sent;

    // Random phases, each under its own settings, drained before the next.
    for (int p = 0; p < PHASES; p++) begin
      configure_phase(p);
      build_pool();
      quiet_sender = (p % 3) == 0;
      quiet_sink   = (p % 4) == 1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // long sink hold-off while the sender keeps pushing: fills the block
        if ((p % 3) == 0 && k == 40) hold_requests++;
        if (!quiet_sender) idle_input(pause_len());
        if (phase_mode(p) == MODE_SMITH) lean = (k < 170) ? LEAN_TAKEN : LEAN_NOT;
        else lean = LEAN_NONE;
        next_branch(lean, pc, t);
        send_branch(pc, t);
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d branches (%0d directed) over %0d settings phases, all modes,",
             branches_sent, directed, PHASES);
    $display("width extremes and %0d long sink hold-offs; %0d predictions compared.",
             hold_served, compared);
    if (mismatches == 0 && pending_verdicts == 0) begin
      $display("[hybrid_branch_predictor_unit] OK");
    end else begin
      $display("[hybrid_branch_predictor_unit] ERROR");
    end
    $finish;
  end

endmodule
